[src/sgm_pkg.sv]
// Shared types and constants for the Sobel gradient magnitude block.
// No dependencies; imported by every module of the block but sgm_ram.
package sgm_pkg;

    localparam int PIX_W = 8;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // 3x3 window, index row*3+col, row 0 = top, col 2 = newest
    typedef logic [8:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t win;
        logic last_in_row;
        logic last_in_frame;
    } job_t;

    function automatic win_t win_shift(win_t w, logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                       logic [PIX_W-1:0] b);
        win_t r;
        r[0] = w[1]; r[1] = w[2]; r[2] = t;
        r[3] = w[4]; r[4] = w[5]; r[5] = m;
        r[6] = w[7]; r[7] = w[8]; r[8] = b;
        return r;
    endfunction

    function automatic win_t win_fill(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                      logic [PIX_W-1:0] b);
        win_t r;
        r[0] = t; r[1] = t; r[2] = t;
        r[3] = m; r[4] = m; r[5] = m;
        r[6] = b; r[7] = b; r[8] = b;
        return r;
    endfunction

endpackage

[src/sobel_gradient_magnitude.sv]
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_front, sgm_queue, sgm_back, sgm_ram.
//
// Usage: grey pixels enter on the s_ channel in raster order (s_tuser = 0),
// drain transactions (s_tuser = 1) release one pending bottom-row result each.
// Results leave on the m_ channel in raster order: m_tdata is the magnitude,
// m_tlast marks the rightmost column, m_tuser the last position of the frame.
// The cfg channel writes image_width (index 0) or image_height (index 1) and
// restarts the frame; write only while the block is idle.
// The front end accepts no new pixel or drain until it has queued the
// results of the last one. The back end works on one result at a time
// (gradients, squares, 8-step square root, output register; the root is
// cut short when the sum saturates) and pops the next job only after
// m_tready takes the result. A completed window passes through the queue
// and the gradient, sum and root registers before it reaches m_tvalid.
// Reset sets 640x480 and clears counters and the window; line stores need
// no clearing. When m_tready is low the result holds, the 4-entry queue
// fills, then s_tready drops.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] magnitude
    output logic        m_tlast,
    output logic        m_tuser    // [0] last_in_frame
);
    import sgm_pkg::*;

    job_t push_job, head;
    logic push, full, pop, empty;

    sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_push(push), .q_job(push_job), .q_full(full)
    );

    sgm_queue u_queue (
        .aclk, .aresetn, .push, .push_job, .full, .pop, .head, .empty
    );

    sgm_back u_back (
        .aclk, .aresetn, .head, .empty, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );
endmodule

[src/sgm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/sgm_front.sv]
// Front end: config registers, raster counters, line stores and 3x3 window.
// Pushes one window job per result into the queue. Uses sgm_pkg, sgm_ram.
module sgm_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    output logic          q_push,
    output sgm_pkg::job_t q_job,
    input  logic          q_full
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        F_IDLE, F_PIX, F_DR0, F_DR1, F_DR2, F_EMIT_A, F_EMIT_B
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [10:0]      iw_reg;
    logic [15:0]      ih_reg;
    logic [AW-1:0]    in_col_reg, out_col_reg, x_reg, c_reg, cr_reg;
    logic [15:0]      in_row_reg, out_row_reg;
    logic             y0_reg, emit2_reg;
    logic [PIX_W-1:0] px_reg;
    win_t             win_reg;

    logic [WW-1:0]    w;
    logic [15:0]      h;
    logic             cfg_fire, s_fire, restart_in, drain_ok, emit1, emit2;
    logic [AW-1:0]    x_acc, cl, cr, rd_addr;
    logic [15:0]      y_acc;
    logic             lr, lf;
    logic [PIX_W-1:0] older_rd, prev_rd;
    win_t             win_pix, win_dup;

    always_comb begin
        if (iw_reg == 11'd0) begin
            w = WW'(1);
        end else if (32'(iw_reg) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(iw_reg);
        end
    end
    assign h = (ih_reg == 16'd0) ? 16'd1 : ih_reg;

    assign cfg_ready = (state_reg == F_IDLE);
    assign s_tready  = (state_reg == F_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_tvalid && s_tready;

    assign restart_in = (in_row_reg >= h) || (WW'(in_col_reg) >= w);
    assign x_acc      = restart_in ? '0 : in_col_reg;
    assign y_acc      = restart_in ? '0 : in_row_reg;
    assign drain_ok   = (in_row_reg >= h) && (out_row_reg < h) && (WW'(out_col_reg) < w);
    assign cl         = (out_col_reg == '0) ? '0 : out_col_reg - AW'(1);
    assign cr         = (WW'(out_col_reg) + WW'(1) < w) ? out_col_reg + AW'(1)
                                                         : AW'(w - WW'(1));

    always_comb begin
        rd_addr = cl;
        unique case (state_reg)
            F_IDLE:  rd_addr = (s_tuser == CMD_PIXEL) ? x_acc : cl;
            F_DR0:   rd_addr = c_reg;
            F_DR1:   rd_addr = cr_reg;
            default: rd_addr = cl;
        endcase
    end

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .aclk, .we(state_reg == F_PIX), .waddr(x_reg),
        .wdata(y0_reg ? px_reg : prev_rd), .raddr(rd_addr), .rdata(older_rd)
    );
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
        .aclk, .we(state_reg == F_PIX), .waddr(x_reg),
        .wdata(px_reg), .raddr(rd_addr), .rdata(prev_rd)
    );

    assign win_pix = (x_reg == '0) ? win_fill(older_rd, prev_rd, px_reg)
                                   : win_shift(win_reg, older_rd, prev_rd, px_reg);
    assign win_dup = win_shift(win_reg, win_reg[2], win_reg[5], win_reg[8]);
    assign emit1   = !y0_reg && (x_reg != '0);
    assign emit2   = !y0_reg && (WW'(x_reg) + WW'(1) == w);

    assign q_push = ((state_reg == F_EMIT_A) || (state_reg == F_EMIT_B)) && !q_full;
    assign lr     = (WW'(out_col_reg) + WW'(1) >= w);
    assign lf     = lr && (17'(out_row_reg) + 17'd1 >= 17'(h));
    assign q_job  = '{win: (state_reg == F_EMIT_B) ? win_dup : win_reg,
                      last_in_row: lr, last_in_frame: lf};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == CMD_PIXEL) begin
                        state_next = F_PIX;
                    end else if (drain_ok) begin
                        state_next = F_DR0;
                    end
                end
            end
            F_PIX: begin
                state_next = emit1 ? F_EMIT_A : (emit2 ? F_EMIT_B : F_IDLE);
            end
            F_DR0:    state_next = F_DR1;
            F_DR1:    state_next = F_DR2;
            F_DR2:    state_next = F_EMIT_A;
            F_EMIT_A: if (!q_full) state_next = emit2_reg ? F_EMIT_B : F_IDLE;
            F_EMIT_B: if (!q_full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            iw_reg      <= WIDTH_RESET;
            ih_reg      <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            win_reg     <= '0;
            emit2_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                if (cfg_index == CFG_IMAGE_WIDTH) begin
                    iw_reg <= cfg_data[10:0];
                end else begin
                    ih_reg <= cfg_data;
                end
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            if (s_fire) begin
                if (s_tuser == CMD_PIXEL) begin
                    px_reg <= s_tdata;
                    x_reg  <= x_acc;
                    y0_reg <= (y_acc == 16'd0);
                    if (restart_in) begin
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    if (WW'(x_acc) + WW'(1) >= w) begin
                        in_col_reg <= '0;
                        in_row_reg <= y_acc + 16'd1;
                    end else begin
                        in_col_reg <= x_acc + AW'(1);
                        in_row_reg <= y_acc;
                    end
                end else begin
                    c_reg  <= out_col_reg;
                    cr_reg <= cr;
                end
            end
            case (state_reg)
                F_PIX: begin
                    if (!y0_reg) win_reg <= win_pix;
                    emit2_reg <= emit2;
                end
                F_DR0: begin
                    win_reg[0] <= older_rd; win_reg[3] <= prev_rd; win_reg[6] <= prev_rd;
                end
                F_DR1: begin
                    win_reg[1] <= older_rd; win_reg[4] <= prev_rd; win_reg[7] <= prev_rd;
                end
                F_DR2: begin
                    win_reg[2] <= older_rd; win_reg[5] <= prev_rd; win_reg[8] <= prev_rd;
                    emit2_reg  <= 1'b0;
                end
                F_EMIT_B: if (!q_full) win_reg <= win_dup;
                default: ;
            endcase
            if (q_push) begin
                if (lf) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if (lr) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 16'd1;
                end else begin
                    out_col_reg <= out_col_reg + AW'(1);
                end
            end
        end
    end

    a_pix_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_PIX) |-> $past(s_fire))
        else $error("pixel stage entered without an accepted transaction");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_fire |=> (in_col_reg == '0) && (in_row_reg == '0) && (out_row_reg == '0))
        else $error("register write did not restart the frame");
endmodule

[src/sgm_queue.sv]
// Short job queue between the window front end and the magnitude back end.
// Uses sgm_pkg.
module sgm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sgm_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output sgm_pkg::job_t head,
    output logic          empty
);
    import sgm_pkg::*;

    localparam int DEPTH = 4;

    job_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign full  = (count_reg == 3'(DEPTH));
    assign empty = (count_reg == 3'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(DEPTH))
        else $error("job queue count out of range");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job queue popped while empty");
endmodule

[src/sgm_back.sv]
// Back end: Sobel gx/gy, sum of squares and bit-serial square root.
// Holds the result in the output register until taken. Uses sgm_pkg.
module sgm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  sgm_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);
    import sgm_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_SQ, B_ROOT, B_OUT} bstate_t;

    bstate_t            state_reg;
    logic signed [10:0] gx_reg, gy_reg;
    logic [20:0]        sum_reg;
    logic [7:0]         r_reg;
    logic [2:0]         k_reg;
    logic               lr_reg, lf_reg;

    logic signed [10:0] gx, gy;
    logic signed [21:0] gx2, gy2;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;

    function automatic logic signed [10:0] px(logic [7:0] p);
        return $signed({3'b000, p});
    endfunction

    assign gx = (px(head.win[2]) + (px(head.win[5]) <<< 1) + px(head.win[8]))
              - (px(head.win[0]) + (px(head.win[3]) <<< 1) + px(head.win[6]));
    assign gy = (px(head.win[6]) + (px(head.win[7]) <<< 1) + px(head.win[8]))
              - (px(head.win[0]) + (px(head.win[1]) <<< 1) + px(head.win[2]));
    assign gx2 = gx_reg * gx_reg;
    assign gy2 = gy_reg * gy_reg;

    assign trial    = r_reg | (8'd1 << k_reg);
    assign trial_sq = trial * trial;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = r_reg;
    assign m_tlast  = lr_reg;
    assign m_tuser  = lf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (pop) begin
                        gx_reg    <= gx;
                        gy_reg    <= gy;
                        lr_reg    <= head.last_in_row;
                        lf_reg    <= head.last_in_frame;
                        state_reg <= B_SQ;
                    end
                end
                B_SQ: begin
                    sum_reg   <= 21'(gx2 + gy2);
                    r_reg     <= '0;
                    k_reg     <= 3'd7;
                    state_reg <= B_ROOT;
                end
                B_ROOT: begin
                    if (sum_reg[20:16] != '0) begin
                        r_reg     <= 8'hFF;
                        state_reg <= B_OUT;
                    end else begin
                        if (trial_sq <= sum_reg[15:0]) r_reg <= trial;
                        k_reg <= k_reg - 3'd1;
                        if (k_reg == 3'd0) state_reg <= B_OUT;
                    end
                end
                B_OUT: if (m_tready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_sq_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SQ) |-> $past(pop))
        else $error("square stage entered without a popped job");
endmodule

[tb/tb_sobel_gradient_magnitude.sv]
// Self-checking testbench for sobel_gradient_magnitude: random-gap stream driver and monitor
// around a behavioral Sobel/line-store predictor of the block.
// Depends on sgm_pkg and the RTL under src/.
module tb_sobel_gradient_magnitude;
    timeunit 1ns;
    timeprecision 1ps;
    import sgm_pkg::*;

    localparam int MAXW = 1024;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_SYNC} op_kind_e;

    typedef struct {
        op_kind_e    kind;
        logic        cmd;
        logic [7:0]  pix;
        logic        idx;
        logic [15:0] val;
    } pend_t;

    typedef struct {
        logic [7:0] mag;
        logic       lr;
        logic       lf;
    } grad_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] pixel
    logic        s_tuser = 1'b0; // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] magnitude
    logic        m_tlast;
    logic        m_tuser;        // [0] last_in_frame

    sobel_gradient_magnitude #(.MAX_WIDTH(MAXW)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    pend_t     pending_ops[$];
    grad_res_t expected_mags[$];
    int        errors = 0;
    int        n_items = 0;
    bit        no_idle = 1'b0;

    // predictor state
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  line_prev[MAXW];
    logic [7:0]  line_older[MAXW];
    logic [7:0]  win9[9];
    int          in_col, in_row, out_col, out_row;

    function automatic int eff_w();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int eff_h();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic logic [7:0] sobel_mag(input logic [7:0] p[9]);
        int gx, gy, s, r, b;
        gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
        gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
        s = gx * gx + gy * gy;
        if (s >= 65536) return 8'd255;
        r = 0;
        for (b = 128; b != 0; b = b >> 1)
            if ((r + b) * (r + b) <= s) r = r + b;
        return r[7:0];
    endfunction

    task automatic restart_counts();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endtask

    task automatic win_push(input logic [7:0] t, input logic [7:0] m, input logic [7:0] b);
        win9[0] = win9[1]; win9[1] = win9[2]; win9[2] = t;
        win9[3] = win9[4]; win9[4] = win9[5]; win9[5] = m;
        win9[6] = win9[7]; win9[7] = win9[8]; win9[8] = b;
    endtask

    task automatic emit_mag(input logic [7:0] mag);
        grad_res_t r;
        r.mag = mag;
        r.lr = (out_col + 1 >= eff_w());
        r.lf = r.lr && (out_row + 1 >= eff_h());
        expected_mags.push_back(r);
        if (r.lf) restart_counts();
        else if (r.lr) begin
            out_col = 0;
            out_row++;
        end else out_col++;
    endtask

    task automatic predict_item(input logic cmd, input logic [7:0] p);
        int w, h, x, y, c, cl, cr;
        logic [7:0] t, m;
        logic [7:0] dw[9];
        w = eff_w();
        h = eff_h();
        if (cmd == CMD_PIXEL) begin
            if (in_row >= h || in_col >= w) restart_counts();
            x = in_col;
            y = in_row;
            if (y == 0) begin
                line_older[x] = p;
                line_prev[x] = p;
            end else begin
                t = line_older[x];
                m = line_prev[x];
                win_push(t, m, p);
                if (x == 0) begin
                    win_push(t, m, p);
                    win_push(t, m, p);
                end
                line_older[x] = m;
                line_prev[x] = p;
                if (x >= 1) emit_mag(sobel_mag(win9));
                if (x + 1 == w) begin
                    win_push(win9[2], win9[5], win9[8]);
                    emit_mag(sobel_mag(win9));
                end
            end
            if (x + 1 >= w) begin
                in_col = 0;
                in_row = y + 1;
            end else in_col = x + 1;
        end else if (in_row >= h && out_row < h && out_col < w) begin
            c = out_col;
            cl = (c == 0) ? 0 : c - 1;
            cr = (c + 1 < w) ? c + 1 : w - 1;
            dw[0] = line_older[cl]; dw[1] = line_older[c]; dw[2] = line_older[cr];
            dw[3] = line_prev[cl];  dw[4] = line_prev[c];  dw[5] = line_prev[cr];
            dw[6] = dw[3]; dw[7] = dw[4]; dw[8] = dw[5];
            emit_mag(sobel_mag(dw));
        end
    endtask

    task automatic predict_cfg(input logic idx, input logic [15:0] v);
        if (idx == CFG_IMAGE_WIDTH) width_reg = v[10:0];
        else height_reg = v;
        restart_counts();
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge aclk)
        if ($urandom_range(0, 399) == 0) no_idle <= ~no_idle;

    // driver
    int    gap_cnt = 0;
    int    quiet_cnt = 0;
    pend_t cur_item;
    always @(posedge aclk) begin : drive
        logic  nv, cv;
        pend_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            nv = s_tvalid;
            cv = cfg_valid;
            if (s_tvalid && s_tready) begin
                predict_item(cur_item.cmd, cur_item.pix);
                nv = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                predict_cfg(cfg_index, cfg_data);
                cv = 1'b0;
            end
            if (expected_mags.size() == 0 && !nv && !s_tvalid) quiet_cnt++;
            else quiet_cnt = 0;
            if (!nv && !cv) begin
                if (gap_cnt > 0) gap_cnt--;
                else if (pending_ops.size() > 0) begin
                    head = pending_ops[0];
                    case (head.kind)
                        OP_ITEM: begin
                            void'(pending_ops.pop_front());
                            cur_item = head;
                            nv = 1'b1;
                            s_tdata <= head.pix;
                            s_tuser <= head.cmd;
                            gap_cnt = pick_gap();
                        end
                        OP_CFG: begin
                            if (quiet_cnt >= 64) begin
                                void'(pending_ops.pop_front());
                                cv = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data <= head.val;
                            end
                        end
                        default: begin
                            if (expected_mags.size() == 0) void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid <= nv;
            cfg_valid <= cv;
        end
    end

    // monitor
    int stall_cnt = 0;
    always @(posedge aclk) begin : monitor
        grad_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mags.size() == 0) begin
                $display("%0t: unexpected result mag=%0d last_row=%0b last_frame=%0b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                e = expected_mags.pop_front();
                if (m_tdata !== e.mag) begin
                    $display("%0t: magnitude expected %0d actual %0d", $time, e.mag, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.lr) begin
                    $display("%0t: last_in_row expected %0b actual %0b", $time, e.lr, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.lf) begin
                    $display("%0t: last_in_frame expected %0b actual %0b", $time, e.lf, m_tuser);
                    errors++;
                end
            end
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
        end
    end

    task automatic add_pixel(input logic [7:0] p);
        pending_ops.push_back('{OP_ITEM, CMD_PIXEL, p, 1'b0, 16'd0});
        n_items++;
    endtask

    task automatic add_drain();
        pending_ops.push_back('{OP_ITEM, CMD_DRAIN, 8'($urandom_range(0, 255)), 1'b0, 16'd0});
        n_items++;
    endtask

    task automatic add_cfg(input logic [15:0] w, input logic [15:0] h);
        pending_ops.push_back('{OP_CFG, CMD_PIXEL, 8'd0, CFG_IMAGE_WIDTH, w});
        pending_ops.push_back('{OP_CFG, CMD_PIXEL, 8'd0, CFG_IMAGE_HEIGHT, h});
    endtask

    task automatic add_sync();
        pending_ops.push_back('{OP_SYNC, CMD_PIXEL, 8'd0, 1'b0, 16'd0});
    endtask

    initial begin : stim
        int w, h, fr, i, k, base, style;
        logic [7:0] pv;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        foreach (win9[j]) win9[j] = '0;
        restart_counts();

        // directed: 3x3 checkerboard of extremes, full drain, extra drain
        add_cfg(16'd3, 16'd3);
        add_drain();
        for (i = 0; i < 9; i++) add_pixel(((i % 2) == 0) ? 8'hFF : 8'h00);
        for (i = 0; i < 4; i++) add_drain();
        add_pixel(8'hAA);
        add_pixel(8'h55);
        // width 0 and height 0 act as 1x1
        add_cfg(16'd0, 16'd0);
        add_pixel(8'h80);
        add_drain();
        add_pixel(8'h7F);
        add_drain();
        add_sync();
        // new frame pixel drops pending bottom-row results
        add_cfg(16'd4, 16'd2);
        for (i = 0; i < 8; i++) add_pixel(8'(i * 37));
        add_drain();
        add_pixel(8'h01);
        // oversized width and tallest height
        add_cfg(16'h07FF, 16'hFFFF);
        for (i = 0; i < 24; i++) add_pixel(8'($urandom_range(0, 255)));
        add_cfg(16'd5, 16'hFFFF);
        for (i = 0; i < 15; i++) add_pixel(8'($urandom_range(0, 255)));
        add_cfg(16'd2, 16'h5A5A);
        for (i = 0; i < 6; i++) add_pixel(8'($urandom_range(0, 255)));

        while (n_items < 550) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            add_cfg(16'(w), 16'(h));
            for (fr = $urandom_range(1, 3); fr > 0; fr--) begin
                style = $urandom_range(0, 2);
                base = $urandom_range(0, 240);
                for (i = 0; i < w * h; i++) begin
                    if (style == 0) pv = 8'($urandom_range(0, 255));
                    else if (style == 1) pv = 8'(base + $urandom_range(0, 15));
                    else pv = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                    add_pixel(pv);
                    if ($urandom_range(0, 19) == 0) add_drain();
                end
                k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w) : w;
                for (i = 0; i < k; i++) add_drain();
                if ($urandom_range(0, 3) == 0) add_drain();
                if ($urandom_range(0, 5) == 0) add_sync();
            end
            if ($urandom_range(0, 4) == 0)
                for (i = 0; i < $urandom_range(1, 4); i++) add_pixel(8'($urandom_range(0, 255)));
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_tvalid || cfg_valid || expected_mags.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_mags.size() == 0) begin
            $display("tb_sobel_gradient_magnitude passed");
        end else begin
            $display("tb_sobel_gradient_magnitude failed");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("tb_sobel_gradient_magnitude failed");
        $finish;
    end

endmodule
